// File: hw/rtl/sha256_block_compression_macros.svh
// Assertion macros for the SHA-256 block compression engine.
// Used by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SHA256_BLOCK_COMPRESSION_MACROS_SVH
`define SHA256_BLOCK_COMPRESSION_MACROS_SVH

`ifndef SYNTHESIS
`define SHA_ASSERT_COMB(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sha256 assertion failed");
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 assertion failed");
`else
`define SHA_ASSERT_COMB(lbl, cond)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/sha256c_pkg.sv
// Shared types, constants and round functions for the SHA-256 compression engine.
// No dependencies.
package sha256c_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] hash_t;

  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  localparam hash_t HASH_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic hash_t sha_round(input hash_t v, input word_t k, input word_t w);
    word_t ch;
    word_t mj;
    word_t t1;
    word_t t2;
    hash_t r;
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + big_sigma1(v[4]) + ch + k + w;
    t2 = big_sigma0(v[0]) + mj;
    r[0] = t1 + t2;
    r[1] = v[0];
    r[2] = v[1];
    r[3] = v[2];
    r[4] = v[3] + t1;
    r[5] = v[4];
    r[6] = v[5];
    r[7] = v[6];
    return r;
  endfunction

endpackage

// File: hw/rtl/sha256c_sched.sv
// Message schedule window: a sixteen-word shift line that takes in the block's words
// and then produces one expanded schedule word per round. Depends on sha256c_pkg.
module sha256c_sched
  import sha256c_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  word_t       load_word,
  output word_t       w_out
);

  word_t win_r [16];
  word_t expand;

  assign expand = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  assign w_out  = win_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= ctrl.load ? load_word : expand;
    end
  end

endmodule

// File: hw/rtl/sha256_block_compression.sv
// SHA-256 block compression engine, top level.
// Depends on sha256c_pkg, sha256c_sched and sha256_block_compression_macros.svh.
//
// Usage: the input channel takes one 32-bit word of the padded message per
// handshake, sixteen words per 512-bit block, big-endian word order. The
// first_block and last_block flags are sampled with the sixteenth word only.
// Words of a block are accepted one per cycle. After the sixteenth word the
// engine runs its 64 rounds, one round per cycle, on a single shared round
// unit, then adds the working variables into the chain hash in the S_ADD
// state before returning to S_LOAD.
// For a last block, the first digest word is valid once S_ADD has registered
// the final hash; the eight words follow at one per cycle while out_ready is high, hash
// word 0 first, the eighth marked by out_digest_last.
// The next block's first fifteen words may be accepted while the digest is
// still being sent; its sixteenth word waits until the receiver has taken all
// eight digest words, so a stalled receiver eventually stalls the input.
// Reset loads the standard initial hash and clears the word count.
module sha256_block_compression
  import sha256c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic        in_first_block,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  `include "sha256_block_compression_macros.svh"

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_ADD
  } state_t;

  state_t      state_r;
  hash_t       hash_r;
  hash_t       vars_r;
  logic [3:0]  word_cnt_r;
  logic [5:0]  round_cnt_r;
  logic        last_r;
  logic        out_valid_r;
  logic [2:0]  out_idx_r;
  logic        in_fire;
  logic        out_fire;
  sched_ctrl_t sched_ctrl;
  word_t       sched_w;

  assign in_ready = (state_r == S_LOAD) && !((word_cnt_r == 4'd15) && out_valid_r);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign out_valid       = out_valid_r;
  assign out_digest_word = hash_r[out_idx_r];
  assign out_digest_last = (out_idx_r == 3'd7);

  assign sched_ctrl.load = in_fire;
  assign sched_ctrl.step = (state_r == S_ROUND);

  sha256c_sched u_sched (
    .clk       (clk),
    .ctrl      (sched_ctrl),
    .load_word (in_message_word),
    .w_out     (sched_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      hash_r      <= HASH_IV;
      word_cnt_r  <= '0;
      round_cnt_r <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      if (out_fire) begin
        if (out_idx_r == 3'd7) begin
          out_valid_r <= 1'b0;
        end
        out_idx_r <= out_idx_r + 3'd1;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            word_cnt_r <= word_cnt_r + 4'd1;
            if (word_cnt_r == 4'd15) begin
              last_r      <= in_last_block;
              round_cnt_r <= '0;
              state_r     <= S_ROUND;
              if (in_first_block) begin
                hash_r <= HASH_IV;
                vars_r <= HASH_IV;
              end else begin
                vars_r <= hash_r;
              end
            end
          end
        end
        S_ROUND: begin
          vars_r      <= sha_round(vars_r, ROUND_K[round_cnt_r], sched_w);
          round_cnt_r <= round_cnt_r + 6'd1;
          if (round_cnt_r == 6'd63) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] + vars_r[i];
          end
          if (last_r) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
          end
          state_r <= S_LOAD;
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  `SHA_ASSERT_COMB(a_no_output_while_rounds, (state_r != S_ROUND) || !out_valid_r)
  `SHA_ASSERT_COMB(a_word_cnt_idle_in_rounds, (state_r == S_LOAD) || (word_cnt_r == 4'd0))
  `SHA_ASSERT_NEXT(a_rounds_end_in_add, (state_r == S_ROUND) && (round_cnt_r == 6'd63), state_r == S_ADD)
  `SHA_ASSERT_NEXT(a_digest_ends, out_fire && out_digest_last, !out_valid_r)

endmodule
